>>> rtl/jvef_pkg.sv
// ----------------------------------------------------------------------------
// jvef_pkg
// Shared types and constants for the JSON value extent finder.
// ----------------------------------------------------------------------------
package jvef_pkg;

  localparam int MaxNesting = 64;
  localparam int DepthW     = $clog2(MaxNesting + 1);
  localparam int AddrW      = (MaxNesting > 1) ? $clog2(MaxNesting) : 1;
  localparam int NestW      = 7;

  localparam logic [7:0] ChNul          = 8'h00;
  localparam logic [7:0] ChQuote        = 8'h22;
  localparam logic [7:0] ChBackslash    = 8'h5C;
  localparam logic [7:0] ChOpenBracket  = 8'h5B;
  localparam logic [7:0] ChCloseBracket = 8'h5D;
  localparam logic [7:0] ChOpenBrace    = 8'h7B;
  localparam logic [7:0] ChCloseBrace   = 8'h7D;

  typedef enum logic [1:0] {
    StScan = 2'd0,
    StDone = 2'd1,
    StErr  = 2'd2,
    StIdle = 2'd3
  } scan_status_e;

  typedef struct packed {
    logic       start_of_value;
    logic [7:0] text_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]       scan_status;
    logic [NestW-1:0] nesting_depth;
  } out_beat_t;

  typedef struct packed {
    logic              value_open;
    logic              inside_string;
    logic              escape_pending;
    logic [DepthW-1:0] open_depth;
    logic              top_kind;
  } scan_state_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic             kind;
  } stack_wr_t;

endpackage

>>> rtl/jvef_ram.sv
// ----------------------------------------------------------------------------
// jvef_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module jvef_ram #(
  parameter int Width = 1,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/jvef_step.sv
// ----------------------------------------------------------------------------
// jvef_step
// Next-state and result logic for one text byte of the scan.
// ----------------------------------------------------------------------------
module jvef_step
  import jvef_pkg::*;
(
  input  in_beat_t    beat_i,
  input  scan_state_t state_i,
  input  logic        below_kind_i,
  output scan_state_t state_o,
  output stack_wr_t   wr_o,
  output out_beat_t   result_o
);

  always_comb begin
    logic [7:0]   c;
    logic         is_open;
    logic         is_close;
    scan_status_e status;

    c        = beat_i.text_byte;
    is_open  = (c == ChOpenBrace) || (c == ChOpenBracket);
    is_close = (c == ChCloseBrace) || (c == ChCloseBracket);
    status   = StScan;
    state_o  = state_i;
    wr_o     = '0;

    if (beat_i.start_of_value) begin
      state_o = '0;
      if (!is_open) begin
        status = StErr;
      end else begin
        state_o.value_open = 1'b1;
        state_o.open_depth = DepthW'(1);
        state_o.top_kind   = (c == ChOpenBracket);
        wr_o.we            = 1'b1;
        wr_o.addr          = '0;
        wr_o.kind          = (c == ChOpenBracket);
      end
    end else if (!state_i.value_open) begin
      status = StIdle;
    end else if (c == ChNul) begin
      state_o = '0;
      status  = StErr;
    end else if (state_i.inside_string) begin
      if (state_i.escape_pending) begin
        state_o.escape_pending = 1'b0;
      end else if (c == ChBackslash) begin
        state_o.escape_pending = 1'b1;
      end else if (c == ChQuote) begin
        state_o.inside_string = 1'b0;
      end
    end else if (c == ChQuote) begin
      state_o.inside_string = 1'b1;
    end else if (is_open) begin
      if (state_i.open_depth >= DepthW'(MaxNesting)) begin
        state_o = '0;
        status  = StErr;
      end else begin
        wr_o.we            = 1'b1;
        wr_o.addr          = state_i.open_depth[AddrW-1:0];
        wr_o.kind          = (c == ChOpenBracket);
        state_o.open_depth = DepthW'(state_i.open_depth + DepthW'(1));
        state_o.top_kind   = (c == ChOpenBracket);
      end
    end else if (is_close) begin
      if ((state_i.open_depth == '0) || (state_i.top_kind != (c == ChCloseBracket))) begin
        state_o = '0;
        status  = StErr;
      end else if (state_i.open_depth == DepthW'(1)) begin
        state_o = '0;
        status  = StDone;
      end else begin
        state_o.open_depth = DepthW'(state_i.open_depth - DepthW'(1));
        state_o.top_kind   = below_kind_i;
      end
    end

    result_o.scan_status   = status;
    result_o.nesting_depth = NestW'(state_o.open_depth);
  end

endmodule

>>> rtl/json_value_extent_finder.sv
// ----------------------------------------------------------------------------
// json_value_extent_finder
// Finds where a JSON object or array ends in a byte stream, one byte a beat.
//
//   channel | dir | payload     | handshake
//   --------+-----+-------------+------------------------
//   in      | in  | in_beat_t   | in_valid_i / in_stall_o
//   out     | out | out_beat_t  | out_valid_o / out_stall_i
//
// one beat per cycle sustained unless out_stall_i holds a result; each beat
// passes the input register, then step logic into the result register
// the bracket stack lives in a ram; its registered read keeps the entry
// under the top ready, and the top itself sits in a flop
// reset clears scan state and valid flags only; the stack ram is not initialized
// a stalled result holds the pipe; the input register still fills behind it
// ----------------------------------------------------------------------------
module json_value_extent_finder
  import jvef_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic        in_vld_q;
  in_beat_t    in_beat_q;
  logic        out_vld_q;
  out_beat_t   out_beat_q;
  scan_state_t state_q;
  scan_state_t state_d;
  scan_state_t step_state;
  stack_wr_t   step_wr;
  out_beat_t   step_result;
  logic        below_kind;
  logic        adv;
  logic        step;
  logic [DepthW-1:0] rd_depth;

  assign adv        = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;

  jvef_step u_step (
    .beat_i       (in_beat_q),
    .state_i      (state_q),
    .below_kind_i (below_kind),
    .state_o      (step_state),
    .wr_o         (step_wr),
    .result_o     (step_result)
  );

  assign state_d  = step ? step_state : state_q;
  assign rd_depth = DepthW'(state_d.open_depth - DepthW'(2));

  jvef_ram #(
    .Width (1),
    .Depth (MaxNesting),
    .AddrW (AddrW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (step && step_wr.we),
    .waddr_i (step_wr.addr),
    .wdata_i (step_wr.kind),
    .raddr_i (rd_depth[AddrW-1:0]),
    .rdata_o (below_kind)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_beat_q <= in_beat_i;
    end
    if (step) begin
      out_beat_q <= step_result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_beat_q;

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.open_depth <= DepthW'(MaxNesting))
    else $error("nesting depth above stack size");

  a_closed_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.value_open |-> (state_q.open_depth == '0) && !state_q.inside_string)
    else $error("closed value with leftover scan state");

  a_open_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.value_open |-> (state_q.open_depth != '0))
    else $error("open value with zero depth");

  a_escape_in_string : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.escape_pending |-> state_q.inside_string)
    else $error("escape pending outside a string");

  a_done_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ((out_beat_q.scan_status == StDone) || (out_beat_q.scan_status == StErr))
    |-> (out_beat_q.nesting_depth == '0))
    else $error("completed or failed beat with nonzero depth");

endmodule
